/* src/msjd_pkg.sv */
// Package for the multi-server job dispatcher: field widths, saturation limits,
// dispatch mode codes and the structs passed between the dispatcher modules.
// No dependencies.
package msjd_pkg;

    localparam int SERVERS_DEF   = 3;
    localparam int TIME_BITS_DEF = 20;

    localparam int FINISH_W  = 48;
    localparam int SUM_W     = 64;
    localparam int IDX_OUT_W = 2;

    localparam logic [FINISH_W-1:0] FINISH_MAX = '1;
    localparam logic [SUM_W-1:0]    SUM_MAX    = '1;

    typedef enum logic {
        MODE_ROUND_ROBIN   = 1'b0,
        MODE_EARLIEST_FREE = 1'b1
    } t_mode;

    localparam t_mode MODE_RESET = MODE_EARLIEST_FREE;

    // Control for one dispatch step of the ledger.
    typedef struct packed {
        logic fire;
        logic start;
    } t_job_ctl;

    // Figures produced by one dispatch step.
    typedef struct packed {
        logic [FINISH_W-1:0] job_wait;
        logic [SUM_W-1:0]    total_wait;
        logic [FINISH_W-1:0] makespan;
    } t_result;

endpackage

/* src/msjd_if.sv */
// Valid/ready stream interfaces for the job dispatcher: job words in, result words out.
// Depends on msjd_pkg for the default time width and the result field widths.
interface msjd_job_if #(
    parameter int TIME_BITS = msjd_pkg::TIME_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] service_time;
    logic                 start_batch;

    modport source (output valid, output service_time, output start_batch, input ready);
    modport sink   (input valid, input service_time, input start_batch, output ready);
endinterface

interface msjd_res_if;
    logic                               valid;
    logic                               ready;
    logic [msjd_pkg::IDX_OUT_W-1:0]     server_index;
    logic [msjd_pkg::FINISH_W-1:0]      job_wait;
    logic [msjd_pkg::SUM_W-1:0]         total_wait;
    logic [msjd_pkg::FINISH_W-1:0]      makespan;

    modport source (output valid, output server_index, output job_wait,
                    output total_wait, output makespan, input ready);
    modport sink   (input valid, input server_index, input job_wait,
                    input total_wait, input makespan, output ready);
endinterface

/* src/multi_server_job_dispatcher_unit.sv */
// Top level of the multi-server job dispatcher: job register, server pick, batch
// ledger and result register. Uses msjd_pkg, msjd_job_if, msjd_res_if, msjd_pick, msjd_ledger.
//
//   channel    | direction | handshake     | word
//   -----------+-----------+---------------+-----------------------------------------------
//   i_job      | in        | valid/ready   | service_time, start_batch
//   o_res      | out       | valid/ready   | server_index, job_wait, total_wait, makespan
//   i_cfg_*    | in        | write enable  | dispatch_mode (1 bit)
//
// One job word per clock while o_res is not stalled. A job waits in the job register, where the pick
// (one min search over the servers), one finish add and one saturating sum settle, and
// moves on into the result register when the job register advances.
// Synchronous active-low reset clears the batch state and sets earliest-free mode.
// When o_res stalls, the result register holds and the job register holds its word;
// i_job.ready drops only when both are full and the result is not being taken.
module multi_server_job_dispatcher_unit #(
    parameter int SERVERS   = msjd_pkg::SERVERS_DEF,
    parameter int TIME_BITS = msjd_pkg::TIME_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    msjd_job_if.sink          i_job,
    msjd_res_if.source        o_res
);

    localparam int IDX_W = $clog2(SERVERS);

    // Configuration register.
    msjd_pkg::t_mode r_mode;

    // Job register (stage one).
    logic                 r_in_valid;
    logic [TIME_BITS-1:0] r_svc;
    logic                 r_start;

    // Result register (stage two).
    logic                           r_out_valid;
    logic [IDX_W-1:0]               r_srv;
    msjd_pkg::t_result              r_res;

    logic                           w_accept;
    logic                           w_adv;
    msjd_pkg::t_job_ctl             w_ctl;
    logic [msjd_pkg::FINISH_W-1:0]  w_finish [SERVERS];
    logic [IDX_W-1:0]               w_rot;
    logic [IDX_W-1:0]               w_srv;
    msjd_pkg::t_result              w_res;

    // Advance the job register whenever the result register is free or being drained.
    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_job.ready = !r_in_valid || w_adv;
    assign w_accept    = i_job.valid && i_job.ready;

    assign w_ctl.fire  = w_adv;
    assign w_ctl.start = r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= msjd_pkg::MODE_RESET;
        end else if (i_cfg_wr_en) begin
            r_mode <= msjd_pkg::t_mode'(i_cfg_wr_data);
        end
    end

    // Stage one: capture the job word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_svc   <= i_job.service_time;
            r_start <= i_job.start_batch;
        end
    end

    // Pick a server against the batch state as seen after an optional start clear.
    msjd_pick #(
        .SERVERS (SERVERS),
        .IDX_W   (IDX_W)
    ) u_pick (
        .i_mode   (r_mode),
        .i_rot    (w_rot),
        .i_finish (w_finish),
        .o_srv    (w_srv)
    );

    // Update finish time, wait sum, makespan and rotation as the job moves on.
    msjd_ledger #(
        .SERVERS   (SERVERS),
        .TIME_BITS (TIME_BITS),
        .IDX_W     (IDX_W)
    ) u_ledger (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_svc    (r_svc),
        .i_srv    (w_srv),
        .o_finish (w_finish),
        .o_rot    (w_rot),
        .o_res    (w_res)
    );

    // Stage two: hold the result word until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_srv <= w_srv;
            r_res <= w_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.server_index = msjd_pkg::IDX_OUT_W'(r_srv);
    assign o_res.job_wait     = r_res.job_wait;
    assign o_res.total_wait   = r_res.total_wait;
    assign o_res.makespan     = r_res.makespan;

`ifndef SYNTHESIS
    // The rotation pointer never leaves the server range while a job is in stage one.
    a_rot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> (w_rot < IDX_W'(SERVERS - 1) || w_rot == IDX_W'(SERVERS - 1)))
        else $error("rotation pointer out of range");

    // A dispatched job never waits longer than the makespan it produces.
    a_span_covers_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |-> w_res.makespan >= w_res.job_wait)
        else $error("makespan below job wait");

    // A job in stage one with an empty result register reaches the output next cycle.
    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("job register failed to advance");

    // Without a start flag the wait sum never shrinks across a dispatch.
    a_sum_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_start && r_out_valid) |-> w_res.total_wait >= r_res.total_wait)
        else $error("total wait decreased within a batch");
`endif

endmodule

/* src/msjd_pick.sv */
// Server selection for the job dispatcher: rotation pointer in round-robin mode,
// lowest finish time (lowest index on a tie) in earliest-free mode. Uses msjd_pkg.
module msjd_pick #(
    parameter int SERVERS = msjd_pkg::SERVERS_DEF,
    parameter int IDX_W   = $clog2(SERVERS)
) (
    input  msjd_pkg::t_mode                i_mode,
    input  logic [IDX_W-1:0]               i_rot,
    input  logic [msjd_pkg::FINISH_W-1:0]  i_finish [SERVERS],
    output logic [IDX_W-1:0]               o_srv
);

    logic [IDX_W-1:0]              w_best;
    logic [msjd_pkg::FINISH_W-1:0] w_best_val;

    // Strict less-than keeps the lowest index on a tie.
    always_comb begin
        w_best     = '0;
        w_best_val = i_finish[0];
        for (int s = 1; s < SERVERS; s++) begin
            if (i_finish[s] < w_best_val) begin
                w_best     = IDX_W'(s);
                w_best_val = i_finish[s];
            end
        end
    end

    always_comb begin
        unique case (i_mode)
            msjd_pkg::MODE_ROUND_ROBIN:   o_srv = i_rot;
            msjd_pkg::MODE_EARLIEST_FREE: o_srv = w_best;
            default:                      o_srv = w_best;
        endcase
    end

endmodule

/* src/msjd_ledger.sv */
// Batch state of the job dispatcher: server finish times, rotation pointer, wait sum
// and makespan, with the saturating update for one job. Uses msjd_pkg.
module msjd_ledger #(
    parameter int SERVERS   = msjd_pkg::SERVERS_DEF,
    parameter int TIME_BITS = msjd_pkg::TIME_BITS_DEF,
    parameter int IDX_W     = $clog2(SERVERS)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  msjd_pkg::t_job_ctl             i_ctl,
    input  logic [TIME_BITS-1:0]           i_svc,
    input  logic [IDX_W-1:0]               i_srv,
    output logic [msjd_pkg::FINISH_W-1:0]  o_finish [SERVERS],
    output logic [IDX_W-1:0]               o_rot,
    output msjd_pkg::t_result              o_res
);

    localparam int FW = msjd_pkg::FINISH_W;
    localparam int SW = msjd_pkg::SUM_W;

    logic [FW-1:0]    r_finish [SERVERS];
    logic [IDX_W-1:0] r_rot;
    logic [SW-1:0]    r_sum;
    logic [FW-1:0]    r_span;

    logic [FW-1:0]    n_finish [SERVERS];
    logic [IDX_W-1:0] n_rot;
    logic [SW-1:0]    n_sum;
    logic [FW-1:0]    n_span;

    logic [SW-1:0]    w_sum_eff;
    logic [FW-1:0]    w_span_eff;
    logic [FW-1:0]    w_wait;
    logic [FW:0]      w_fin_raw;
    logic [FW-1:0]    w_fin;
    logic [SW:0]      w_sum_raw;

    // A start flag drops the batch before this job is placed.
    always_comb begin
        for (int s = 0; s < SERVERS; s++) begin
            o_finish[s] = i_ctl.start ? '0 : r_finish[s];
        end
        o_rot      = i_ctl.start ? '0 : r_rot;
        w_sum_eff  = i_ctl.start ? '0 : r_sum;
        w_span_eff = i_ctl.start ? '0 : r_span;
    end

    always_comb begin
        w_wait    = o_finish[i_srv];
        w_fin_raw = {1'b0, w_wait} + (FW+1)'(i_svc);
        w_fin     = w_fin_raw[FW] ? msjd_pkg::FINISH_MAX : w_fin_raw[FW-1:0];
        w_sum_raw = {1'b0, w_sum_eff} + (SW+1)'(w_wait);
        n_sum     = w_sum_raw[SW] ? msjd_pkg::SUM_MAX : w_sum_raw[SW-1:0];
        // Finish times only grow within a batch, so the running max is enough.
        n_span    = (w_fin > w_span_eff) ? w_fin : w_span_eff;
        n_rot     = (o_rot == IDX_W'(SERVERS - 1)) ? '0 : o_rot + 1'b1;
        for (int s = 0; s < SERVERS; s++) begin
            n_finish[s] = (i_srv == IDX_W'(s)) ? w_fin : o_finish[s];
        end
    end

    assign o_res.job_wait   = w_wait;
    assign o_res.total_wait = n_sum;
    assign o_res.makespan   = n_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SERVERS; s++) begin
                r_finish[s] <= '0;
            end
            r_rot  <= '0;
            r_sum  <= '0;
            r_span <= '0;
        end else if (i_ctl.fire) begin
            for (int s = 0; s < SERVERS; s++) begin
                r_finish[s] <= n_finish[s];
            end
            r_rot  <= n_rot;
            r_sum  <= n_sum;
            r_span <= n_span;
        end
    end

endmodule
